### hdl/sos_blink_code_led_sequencer_defines.svh
// ----------------------------------------------------------------------------
// SOS blink-code sequencer assertion macros
// Shared property wrappers for the sequencer checks.
// ----------------------------------------------------------------------------
`ifndef SOS_BLINK_CODE_LED_SEQUENCER_DEFINES_SVH
`define SOS_BLINK_CODE_LED_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SOS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define SOS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer next-cycle check failed");

`endif

### hdl/sosblk_pkg.sv
// ----------------------------------------------------------------------------
// SOS blink-code sequencer package
// Request/result types, opcodes and phase durations in millisecond ticks.
// ----------------------------------------------------------------------------
package sosblk_pkg;

  localparam int MS_W = 10;

  // Request opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Group index of the code group (preamble groups are 0..2)
  localparam logic [1:0] GRP_CODE = 2'd3;

  // Phase durations in ms
  localparam logic [MS_W-1:0] T_SHORT_ON = 10'd150;
  localparam logic [MS_W-1:0] T_LONG_ON  = 10'd300;
  localparam logic [MS_W-1:0] T_GAP      = 10'd100;
  localparam logic [MS_W-1:0] T_SOS_END  = 10'd900;
  localparam logic [MS_W-1:0] T_CODE_END = 10'd800;

  typedef struct packed {
    logic       op;
    logic [7:0] error_code;
  } in_req_t;

  typedef struct packed {
    logic led_lit;
    logic busy_res;
    logic finished;
  } out_res_t;

  function automatic logic [MS_W-1:0] on_time(input logic [1:0] g);
    logic [MS_W-1:0] t;
    case (g)
      2'd1:    t = T_LONG_ON;
      GRP_CODE: t = T_LONG_ON;
      default: t = T_SHORT_ON;
    endcase
    return t;
  endfunction

  function automatic logic [MS_W-1:0] off_time(input logic [1:0] g);
    logic [MS_W-1:0] t;
    case (g)
      GRP_CODE: t = T_LONG_ON;
      default:  t = T_GAP;
    endcase
    return t;
  endfunction

  function automatic logic [MS_W-1:0] pause_time(input logic [1:0] g);
    logic [MS_W-1:0] t;
    case (g)
      2'd2:     t = T_SOS_END;
      GRP_CODE: t = T_CODE_END;
      default:  t = T_GAP;
    endcase
    return t;
  endfunction

endpackage

### hdl/sos_blink_code_led_sequencer.sv
// ----------------------------------------------------------------------------
// SOS blink-code LED sequencer
// Each request passes the input register and then the result register. Throughput:
// 1 request per cycle while no result is stalled; the input register holds one
// request while a result is stalled. Reset clears the sequence and both stages.
// ----------------------------------------------------------------------------
`include "sos_blink_code_led_sequencer_defines.svh"

module sos_blink_code_led_sequencer #(
  parameter int PASSES           = 2,
  parameter int PREAMBLE_FLASHES = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sosblk_pkg::in_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sosblk_pkg::out_res_t out_data
);
  import sosblk_pkg::*;

  typedef enum logic [1:0] {
    PH_ON    = 2'd0,
    PH_OFF   = 2'd1,
    PH_PAUSE = 2'd2
  } phase_t;

  localparam logic [7:0] PRE_COUNT = 8'(PREAMBLE_FLASHES);

  // Input stage
  logic    req_valid;
  in_req_t req;

  // Sequence state
  logic            running, running_next;
  logic            pass_index, pass_index_next;
  logic [1:0]      group_index, group_index_next;
  phase_t          flash_phase, flash_phase_next;
  logic [7:0]      flashes_left, flashes_left_next;
  logic [MS_W-1:0] ms_left, ms_left_next;
  logic [7:0]      held_code, held_code_next;
  logic            done;

  logic            adv;
  logic            in_take;
  logic [MS_W-1:0] ms_dec;
  logic [7:0]      fl_dec;
  logic [1:0]      g_nxt;
  logic [7:0]      g_count;

  // Advance the request into the sequencer when the result slot frees up
  assign adv      = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !adv;
  assign in_take  = in_valid && !in_stall;

  assign ms_dec  = ms_left - MS_W'(ms_left != '0);
  assign fl_dec  = flashes_left - 8'(flashes_left != '0);
  assign g_nxt   = group_index + 2'd1;
  assign g_count = (g_nxt == GRP_CODE) ? held_code : PRE_COUNT;

  // Step the phase machine for one request
  always_comb begin
    running_next      = running;
    pass_index_next   = pass_index;
    group_index_next  = group_index;
    flash_phase_next  = flash_phase;
    flashes_left_next = flashes_left;
    ms_left_next      = ms_left;
    held_code_next    = held_code;
    done              = 1'b0;
    if (req.op == OP_START) begin
      if (!running) begin
        held_code_next    = req.error_code;
        running_next      = 1'b1;
        pass_index_next   = 1'b0;
        group_index_next  = 2'd0;
        flashes_left_next = PRE_COUNT;
        flash_phase_next  = PH_ON;
        ms_left_next      = on_time(2'd0);
      end
    end else if (running) begin
      ms_left_next = ms_dec;
      if (ms_dec == '0) begin
        case (flash_phase)
          PH_ON: begin
            flash_phase_next = PH_OFF;
            ms_left_next     = off_time(group_index);
          end
          PH_OFF: begin
            flashes_left_next = fl_dec;
            if (fl_dec != '0) begin
              flash_phase_next = PH_ON;
              ms_left_next     = on_time(group_index);
            end else begin
              flash_phase_next = PH_PAUSE;
              ms_left_next     = pause_time(group_index);
            end
          end
          default: begin
            if (group_index != GRP_CODE) begin
              // Enter the next group; an empty group plays its pause only
              group_index_next = g_nxt;
              if (g_count == '0) begin
                flashes_left_next = '0;
                flash_phase_next  = PH_PAUSE;
                ms_left_next      = pause_time(g_nxt);
              end else begin
                flashes_left_next = g_count;
                flash_phase_next  = PH_ON;
                ms_left_next      = on_time(g_nxt);
              end
            end else if (int'(pass_index) + 1 < PASSES) begin
              pass_index_next   = pass_index + 1'b1;
              group_index_next  = 2'd0;
              flashes_left_next = PRE_COUNT;
              flash_phase_next  = PH_ON;
              ms_left_next      = on_time(2'd0);
            end else begin
              running_next      = 1'b0;
              pass_index_next   = 1'b0;
              group_index_next  = 2'd0;
              flash_phase_next  = PH_ON;
              flashes_left_next = '0;
              ms_left_next      = '0;
              done              = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Hold the input register; refill on accept, drop once advanced
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_take) begin
      req_valid <= 1'b1;
    end else if (adv) begin
      req_valid <= 1'b0;
    end
    if (in_take) begin
      req <= in_data;
    end
  end

  // Update sequence state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      pass_index   <= 1'b0;
      group_index  <= 2'd0;
      flash_phase  <= PH_ON;
      flashes_left <= '0;
      ms_left      <= '0;
      held_code    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (adv) begin
        running      <= running_next;
        pass_index   <= pass_index_next;
        group_index  <= group_index_next;
        flash_phase  <= flash_phase_next;
        flashes_left <= flashes_left_next;
        ms_left      <= ms_left_next;
        held_code    <= held_code_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (adv) begin
      out_data.led_lit  <= running_next && (flash_phase_next == PH_ON);
      out_data.busy_res <= running_next;
      out_data.finished <= done;
    end
  end

  // Checks
  `SOS_ASSERT_NOW(a_fin_not_busy, out_valid && out_data.finished, !out_data.busy_res)
  `SOS_ASSERT_NOW(a_lit_busy, out_valid && out_data.led_lit, out_data.busy_res)
  `SOS_ASSERT_NOW(a_run_time_left, running, ms_left != '0)
  `SOS_ASSERT_NEXT(a_req_held, req_valid && out_valid && out_stall, req_valid)

endmodule
